>>> hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: action and status
// codes, the decoded command that travels from the front to the back part.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned STATUS_W     = 2;

  // Depth of the command queue between front and back
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DROP_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DROP_BACK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LIST       = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_LISTED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_DROP_FRONT,
    OP_DROP_BACK,
    OP_LIST,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

endpackage

>>> hdl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_in_if / dq_out_if
// Valid/ready channels of the double-ended queue: request beats in,
// result beats out.
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic                                valid;
  logic                                ready;
  logic [dq_pkg::ACTION_W-1:0]         action;
  logic signed [dq_pkg::WORD_W-1:0]    value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface dq_out_if;
  logic                                valid;
  logic                                ready;
  logic [dq_pkg::STATUS_W-1:0]         status;
  logic signed [dq_pkg::WORD_W-1:0]    entry;
  logic                                last;

  modport source (output valid, output status, output entry, output last, input ready);
  modport sink   (input valid, input status, input entry, input last, output ready);
endinterface

>>> hdl/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front
// Accept request beats, decode the action into a command and hold it in a
// register until the command queue takes it.
// ----------------------------------------------------------------------------
module dq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  dq_in_if.sink         in_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output dq_pkg::cmd_t  cmd_o
);
  import dq_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  op_e  op_dec;
  logic take;

  always_comb begin
    unique case (in_i.action)
      ACT_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      ACT_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      ACT_DROP_FRONT: op_dec = OP_DROP_FRONT;
      ACT_DROP_BACK:  op_dec = OP_DROP_BACK;
      ACT_LIST:       op_dec = OP_LIST;
      default:        op_dec = OP_NOP;
    endcase
  end

  assign in_i.ready = !valid_q || cmd_ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d     = 1'b1;
      cmd_d.op    = op_dec;
      cmd_d.value = in_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> hdl/dq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dq_cmd_fifo
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module dq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  dq_pkg::cmd_t  wr_cmd_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output dq_pkg::cmd_t  rd_cmd_o
);
  import dq_pkg::*;

  cmd_t                 slot_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 push, pop;

  assign wr_ready_o = cnt_q != CMD_CNT_W'(CMD_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_cmd_o   = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
    return (p == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : p + CMD_PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CMD_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CMD_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

>>> hdl/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back
// Carry out queue commands on the circular store and drive result beats
// through an output register. A list walks the store one entry a cycle while out_o is not stalled.
// ----------------------------------------------------------------------------
module dq_back #(
  parameter int unsigned CAPACITY = dq_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  dq_pkg::cmd_t  cmd_i,
  dq_out_if.source      out_o
);
  import dq_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = IDX_W + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic signed [WORD_W-1:0] mem [CAPACITY];
  logic signed [WORD_W-1:0] rd_data_q;

  logic             state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;

  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q, out_status_d;
  logic signed [WORD_W-1:0] out_entry_q, out_entry_d;
  logic                     out_last_q, out_last_d;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             out_free, full, empty;
  logic [IDX_W-1:0] front_inc, front_dec, back_addr;
  logic [SUM_W-1:0] back_sum;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  assign full      = occ_q == CNT_W'(CAPACITY);
  assign empty     = occ_q == '0;
  assign out_free  = !out_valid_q || out_o.ready;
  assign front_inc = wrap_inc(front_q);
  assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - IDX_W'(1);
  assign back_sum  = SUM_W'(front_q) + SUM_W'(occ_q);
  assign back_addr = (back_sum >= SUM_W'(CAPACITY)) ? IDX_W'(back_sum - SUM_W'(CAPACITY))
                                                    : IDX_W'(back_sum);

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    occ_d        = occ_q;
    rem_d        = rem_q;
    ptr_d        = ptr_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    wr_addr      = back_addr;
    rd_addr      = ptr_q;
    cmd_ready_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o  = 1'b1;
          out_valid_d  = 1'b1;
          out_status_d = ST_DONE;
          out_entry_d  = '0;
          out_last_d   = 1'b1;
          unique case (cmd_i.op)
            OP_PUSH_FRONT: begin
              if (full) begin
                out_status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = front_dec;
                front_d = front_dec;
                occ_d   = occ_q + CNT_W'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                out_status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = back_addr;
                occ_d   = occ_q + CNT_W'(1);
              end
            end
            OP_DROP_FRONT: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                front_d = front_inc;
                occ_d   = occ_q - CNT_W'(1);
              end
            end
            OP_DROP_BACK: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                occ_d = occ_q - CNT_W'(1);
              end
            end
            OP_LIST: begin
              if (!empty) begin
                // no beat yet: fetch the front entry first
                out_valid_d = 1'b0;
                rd_en       = 1'b1;
                rd_addr     = front_q;
                ptr_d       = front_inc;
                rem_d       = occ_q;
                state_d     = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_LISTED;
          out_entry_d  = rd_data_q;
          out_last_d   = rem_q == CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_q;
            ptr_d   = wrap_inc(ptr_q);
            rem_d   = rem_q - CNT_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      rem_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      occ_q       <= occ_d;
      rem_q       <= rem_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.entry  = out_entry_q;
  assign out_o.last   = out_last_q;

endmodule

>>> hdl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries request beats: action (push front, push back, drop front,
//         drop back, list all) and the word to push.
//   out_o carries result beats: status, entry and last. Every request gives
//         one beat with last set, except a list of a non-empty queue, which
//         gives one beat per held entry, front to back, last on the final one.
// Path: a taken request beat passes the front register, the command queue and
//   the result register of the back part; a non-empty list shows its first
//   entry after the store read.
// Throughput: push, drop and empty list complete at one per cycle while out_o
//   is not stalled. A list holds the back part up to its last entry, set by the single read
//   port of the store; requests keep queuing up to the command queue depth.
// Reset: the queue is empty, the front index is zero, no beat is pending.
//   Store contents are not cleared; only written entries are ever read.
// Stall: a stalled out_o holds its beat, stops the back part, then the input.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int unsigned CAPACITY = dq_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dq_in_if.sink     in_i,
  dq_out_if.source  out_o
);
  import dq_pkg::*;

  // decoded command from the front register into the queue
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;

  // command from the queue into the back part
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  // Decode and register each request beat
  dq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  // Buffer commands so a long list does not stall the input at once
  dq_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_cmd_i   (fr_cmd),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_cmd_o   (bk_cmd)
  );

  // Execute on the store and drive result beats
  dq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .out_o       (out_o)
  );

endmodule

>>> hdl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the result channel of the double-ended queue.
// ----------------------------------------------------------------------------
module dq_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [dq_pkg::STATUS_W-1:0]      out_status_i,
  input  logic signed [dq_pkg::WORD_W-1:0] out_entry_i,
  input  logic                             out_last_i
);
  import dq_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_entry_i) && $stable(out_last_i))
    else $error("result beat changed while stalled");

  // only listed entries carry a word
  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_LISTED |-> out_entry_i == '0)
    else $error("non-list result carries a nonzero entry");

  // a non-list result is always the only one of its request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_LISTED |-> out_last_i)
    else $error("non-list result without last");

  // a list beat without last is followed by another list beat
  a_list_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_status_i == ST_LISTED && !out_last_i
      |=> !out_valid_i || out_status_i == ST_LISTED)
    else $error("list interrupted before its last entry");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_entry_i  (out_o.entry),
  .out_last_i   (out_o.last)
);

>>> verif/double_ended_queue_top_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top_test
// Self-checking bench for the bounded double-ended queue. A short directed
// table walks the empty, full and spare-action cases, then random traffic
// alternates fill and drain stretches under four pacing phases. Every result
// beat is checked against a behavioral copy of the queue kept in the bench.
// ----------------------------------------------------------------------------
module double_ended_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int unsigned DQ_CAP  = CAPACITY_DEF;
  localparam int unsigned FRONT_W = $clog2(DQ_CAP);
  localparam int unsigned FILL_W  = $clog2(DQ_CAP + 1);

  // Action codes the block does not define; they must answer done and change nothing
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_C = 3'd7;

  localparam int unsigned RANDOM_BEATS = 280;
  localparam int unsigned STRETCH_LEN  = 28;   // beats per fill or drain stretch
  localparam int unsigned TAIL_CYCLES  = 8;    // tail watched for stray beats after the drain
  localparam int unsigned STUCK_LIMIT  = 4000; // cycles with no beat on either side

  logic clk = 1'b0;
  logic rst_n;

  dq_in_if  req_if ();
  dq_out_if res_if ();

  double_ended_queue_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the queue and the results it predicts
  // --------------------------------------------------------------------------
  typedef struct {
    status_e                  status;
    logic signed [WORD_W-1:0] entry;
    logic                     last;
  } result_t;

  result_t expected_results [$];

  logic signed [WORD_W-1:0] mirror_words [DQ_CAP];
  logic [FRONT_W-1:0]       mirror_front;
  logic [FILL_W-1:0]        mirror_fill;

  int unsigned err_count     = 0;
  int unsigned req_beats     = 0;
  int unsigned res_beats     = 0;
  int unsigned full_refusals = 0;
  int unsigned empty_drops   = 0;
  int unsigned list_walks    = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  function automatic void add_expect(status_e st, logic signed [WORD_W-1:0] word, logic lst,
                                     bit keep);
    result_t r;
    r.status = st;
    r.entry  = word;
    r.last   = lst;
    if (keep) expected_results.push_back(r);
  endfunction

  // Advance the mirror by one request; queue its results when keep is set
  function automatic void predict_queue(logic [ACTION_W-1:0] act,
                                        logic signed [WORD_W-1:0] val, bit keep);
    int slot;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (mirror_fill == FILL_W'(DQ_CAP)) begin
          full_refusals++;
          add_expect(ST_FULL, '0, 1'b1, keep);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            mirror_front = FRONT_W'((int'(mirror_front) + DQ_CAP - 1) % DQ_CAP);
            slot = int'(mirror_front);
          end else begin
            slot = (int'(mirror_front) + int'(mirror_fill)) % DQ_CAP;
          end
          mirror_words[slot] = val;
          mirror_fill++;
          add_expect(ST_DONE, '0, 1'b1, keep);
        end
      end
      ACT_DROP_FRONT, ACT_DROP_BACK: begin
        if (mirror_fill == '0) begin
          empty_drops++;
          add_expect(ST_EMPTY, '0, 1'b1, keep);
        end else begin
          // Drop back only shrinks the count; the front stays put
          if (act == ACT_DROP_FRONT)
            mirror_front = FRONT_W'((int'(mirror_front) + 1) % DQ_CAP);
          mirror_fill--;
          add_expect(ST_DONE, '0, 1'b1, keep);
        end
      end
      ACT_LIST: begin
        list_walks++;
        if (mirror_fill == '0) begin
          add_expect(ST_DONE, '0, 1'b1, keep);
        end else begin
          for (int k = 0; k < int'(mirror_fill); k++) begin
            slot = (int'(mirror_front) + k) % DQ_CAP;
            add_expect(ST_LISTED, mirror_words[slot], (k + 1 == int'(mirror_fill)), keep);
          end
        end
      end
      default: add_expect(ST_DONE, '0, 1'b1, keep);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side: present one beat, hold it until taken
  // --------------------------------------------------------------------------
  task automatic send_request(logic [ACTION_W-1:0] act, logic signed [WORD_W-1:0] val,
                              bit typed, status_e typed_status);
    // Insert idle cycles first, so gaps land on any phase of the back part
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.value  <= val;
    do @(posedge clk); while (!req_if.ready);
    req_beats++;
    // Typed rows carry their own single result; the mirror still advances
    if (typed) begin
      add_expect(typed_status, '0, 1'b1, 1'b1);
      predict_queue(act, val, 1'b0);
    end else begin
      predict_queue(act, val, 1'b1);
    end
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Fill stretches lean on pushes to hit the full case, drain stretches on drops
  function automatic logic [ACTION_W-1:0] pick_action(bit filling);
    int unsigned r;
    int unsigned push_pct;
    int unsigned drop_pct;
    r        = $urandom_range(99);
    push_pct = filling ? 65 : 22;
    drop_pct = filling ? 20 : 60;
    if (r < push_pct)
      return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    if (r < push_pct + drop_pct)
      return $urandom_range(1) ? ACT_DROP_FRONT : ACT_DROP_BACK;
    if (r < 95)
      return ACT_LIST;
    case ($urandom_range(2))
      0:       return ACT_SPARE_A;
      1:       return ACT_SPARE_B;
      default: return ACT_SPARE_C;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random backpressure and the check against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && res_if.valid && res_if.ready) begin
      res_beats++;
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result beat: status %0d entry %0d last %0b", $realtime,
                 res_if.status, res_if.entry, res_if.last);
      end else begin
        want = expected_results.pop_front();
        if (res_if.status !== want.status) begin
          err_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d", $realtime,
                   want.status, res_if.status);
        end
        if (res_if.entry !== want.entry) begin
          err_count++;
          $display("%0t: entry mismatch: expected %0d, actual %0d", $realtime,
                   want.entry, res_if.entry);
        end
        if (res_if.last !== want.last) begin
          err_count++;
          $display("%0t: last mismatch: expected %0b, actual %0b", $realtime,
                   want.last, res_if.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither side moves a beat for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles", $realtime, STUCK_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Directed table: empty and spare actions first, then extremes of the word,
  // wrap of the front index, filling to capacity and refusals when full
  // --------------------------------------------------------------------------
  typedef struct {
    logic [ACTION_W-1:0]      act;
    logic signed [WORD_W-1:0] val;
    int unsigned              reps;   // repeat count; the word advances by one each time
    bit                       typed;  // result written here rather than predicted
    status_e                  status;
  } stim_row_t;

  localparam int unsigned N_ROWS = 19;

  stim_row_t directed_rows [N_ROWS] = '{
    '{ACT_DROP_FRONT, 32'sh0000_0000, 1, 1'b1, ST_EMPTY},
    '{ACT_DROP_BACK,  32'sh0000_0000, 1, 1'b1, ST_EMPTY},
    '{ACT_LIST,       32'sh0000_0000, 1, 1'b1, ST_DONE},
    '{ACT_SPARE_A,    32'sh0000_1234, 1, 1'b1, ST_DONE},
    '{ACT_SPARE_B,    32'shffff_ffff, 1, 1'b1, ST_DONE},
    '{ACT_SPARE_C,    32'sh0000_0000, 1, 1'b1, ST_DONE},
    '{ACT_PUSH_FRONT, 32'sh7fff_ffff, 1, 1'b0, ST_DONE},
    '{ACT_PUSH_BACK,  32'sh8000_0000, 1, 1'b0, ST_DONE},
    '{ACT_PUSH_FRONT, 32'shffff_ffff, 1, 1'b0, ST_DONE},
    '{ACT_PUSH_BACK,  32'sh0000_0000, 1, 1'b0, ST_DONE},
    '{ACT_LIST,       32'sh0000_0000, 1, 1'b0, ST_DONE},
    '{ACT_DROP_BACK,  32'sh0000_0000, 1, 1'b0, ST_DONE},
    '{ACT_DROP_FRONT, 32'sh0000_0000, 1, 1'b0, ST_DONE},
    '{ACT_PUSH_FRONT, 32'sh5555_0000, 7, 1'b0, ST_DONE},
    '{ACT_PUSH_BACK,  32'shaaaa_0000, 7, 1'b0, ST_DONE},
    '{ACT_PUSH_FRONT, 32'sh0000_0001, 1, 1'b1, ST_FULL},
    '{ACT_PUSH_BACK,  32'sh0000_0002, 1, 1'b1, ST_FULL},
    '{ACT_LIST,       32'sh0000_0000, 1, 1'b0, ST_DONE},
    '{ACT_DROP_BACK,  32'sh0000_0000, 1, 1'b0, ST_DONE}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned beat_no;
    int unsigned phase_beats;
    stim_row_t   row;

    rst_n         <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.action <= ACT_PUSH_FRONT;
    req_if.value  <= '0;
    mirror_front  = '0;
    mirror_fill   = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run with no idling on either side
    for (int i = 0; i < N_ROWS; i++) begin
      row = directed_rows[i];
      for (int unsigned k = 0; k < row.reps; k++)
        send_request(row.act, row.val + WORD_W'(k), row.typed, row.status);
    end

    // Random traffic over four pacing phases: none, sender gaps, receiver
    // stalls, both together
    beat_no     = 0;
    phase_beats = RANDOM_BEATS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int unsigned k = 0; k < phase_beats + ((ph == 3) ? RANDOM_BEATS % 4 : 0); k++) begin
        send_request(pick_action(((beat_no / STRETCH_LEN) % 2) == 0), pick_word(),
                     1'b0, ST_DONE);
        beat_no++;
      end
    end
    req_if.valid <= 1'b0;

    // Drain: wait for every predicted beat, then watch the tail for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d result beats under four pacing phases;",
             req_beats, res_beats);
    $display("  %0d pushes refused when full, %0d drops on empty, %0d list walks.",
             full_refusals, empty_drops, list_walks);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/dq_pkg.sv
hdl/dq_if.sv
hdl/dq_front.sv
hdl/dq_cmd_fifo.sv
hdl/dq_back.sv
hdl/double_ended_queue_top.sv
hdl/dq_checker.sv
verif/double_ended_queue_top_test.sv
